FILE: design/sthl_pkg.sv
// Shared constants and types for the segment table height lookup.
package sthl_pkg;
   localparam int MAX_SEGMENTS = 64;
   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic signed [31:0] x1;
      logic signed [31:0] y1;
      logic signed [31:0] x2;
      logic signed [31:0] y2;
   } seg_type;

   typedef struct packed {
      logic        valid;
      logic        found;
      logic signed [31:0] x;
      seg_type     seg;
   } probe_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_MUL, S_DIV, S_DONE, S_OUT
   } state_type;
endpackage

FILE: design/sthl_cell.sv
// One cell of the segment chain: holds a segment and tests the passing probe.
module sthl_cell (
   input  logic                clock,
   input  logic                load,
   input  sthl_pkg::seg_type   load_seg,
   input  logic                active,
   input  sthl_pkg::probe_type probe_in,
   output sthl_pkg::probe_type probe_out
);
   sthl_pkg::seg_type   seg_ff;
   sthl_pkg::probe_type probe_ff, probe_in_c;
   logic                hit;

   assign hit = active && probe_in.valid &&
                probe_in.x >= seg_ff.x1 && probe_in.x <= seg_ff.x2;

   always_comb begin
      probe_in_c = probe_in;
      if (hit) begin
         probe_in_c.found = 1'b1;
         probe_in_c.seg   = seg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) seg_ff <= load_seg;
      probe_ff <= probe_in_c;
   end

   assign probe_out = probe_ff;
endmodule

FILE: design/sthl_divider.sv
// Restoring divider: 64-bit magnitude product by 33-bit divisor, one bit a cycle.
module sthl_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff;
   logic [33:0] rem_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff;
   logic [33:0] trial;
   logic [34:0] diff;

   assign trial = {rem_ff[32:0], q_ff[63]};
   assign diff  = {1'b0, trial} - {2'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'd0;
            q_ff    <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            if (!diff[34]) rem_ff <= diff[33:0];
            else rem_ff <= trial;
            q_ff   <= {q_ff[62:0], ~diff[34]};
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   assign quotient = q_ff;
endmodule

FILE: design/segment_table_height_lookup.sv
// Top level of the segment table height lookup.
// Add, clear and unused commands: the result beat is loaded from the status register.
// Query: probe walks the MAX_SEGMENTS-cell chain one cell a cycle; a miss or vertical
// segment answers straight from the scan, else the height takes a multiply state and
// a restoring divide first. One item in flight; the next beat is taken once the result
// has moved into the output register. Sync reset empties the table.
module segment_table_height_lookup (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_left_x,
   input  logic signed [31:0] req_left_y,
   input  logic signed [31:0] req_right_x,
   input  logic signed [31:0] req_right_y,
   input  logic signed [31:0] req_query_x,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_height_y
);
   localparam int N = sthl_pkg::MAX_SEGMENTS;

   sthl_pkg::state_type state_ff, state_in;
   logic [sthl_pkg::CNT_W-1:0] count_ff, count_in;
   logic [$clog2(N+1)-1:0] scan_ff, scan_in;
   sthl_pkg::probe_type chain [0:N];
   sthl_pkg::probe_type probe_ff, probe_in;
   sthl_pkg::seg_type   new_seg;
   logic [N-1:0] load;
   logic accept;
   logic [1:0]  status_ff, status_in;
   logic signed [31:0] height_ff, height_in;
   logic        neg_ff;
   logic [31:0] mag_ff, ndx_ff;
   logic [32:0] den_ff;
   logic [63:0] prod_ff;
   logic        div_start, div_done;
   logic [63:0] quot;
   logic signed [34:0] sum;
   logic        out_valid_ff;
   logic [1:0]  out_status_ff;
   logic signed [31:0] out_height_ff;
   logic        out_load;

   assign new_seg = '{x1: req_left_x, y1: req_left_y, x2: req_right_x, y2: req_right_y};
   assign req_stall = (state_ff != sthl_pkg::S_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_load = (state_ff == sthl_pkg::S_OUT) && (!out_valid_ff || !rsp_stall);
   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_height_y = out_height_ff;

   always_comb begin
      chain[0] = '0;
      chain[0].valid = accept && req_cmd == sthl_pkg::CMD_QUERY;
      chain[0].x = req_query_x;
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         assign load[g] = accept && req_cmd == sthl_pkg::CMD_ADD &&
                          count_ff == sthl_pkg::CNT_W'(g);
         sthl_cell u_cell (
            .clock(clock), .load(load[g]), .load_seg(new_seg),
            .active(count_ff > sthl_pkg::CNT_W'(g)),
            .probe_in(chain[g]), .probe_out(chain[g+1])
         );
      end
   endgenerate

   sthl_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(prod_ff), .divisor(den_ff), .done(div_done), .quotient(quot)
   );

   assign sum = {{3{probe_ff.seg.y1[31]}}, probe_ff.seg.y1} +
                (neg_ff ? -$signed({2'b0, quot[32:0]}) : $signed({2'b0, quot[32:0]}));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sthl_pkg::S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
      end
      if (out_load) begin
         out_status_ff <= status_ff;
         out_height_ff <= height_ff;
      end
      scan_ff   <= scan_in;
      probe_ff  <= probe_in;
      status_ff <= status_in;
      height_ff <= height_in;
      if (state_ff == sthl_pkg::S_SCAN && scan_ff == ($clog2(N+1))'(N - 1)) begin
         neg_ff <= chain[N].seg.y2 < chain[N].seg.y1;
         mag_ff <= (chain[N].seg.y2 < chain[N].seg.y1)
                   ? 32'(34'(chain[N].seg.y1) - 34'(chain[N].seg.y2))
                   : 32'(34'(chain[N].seg.y2) - 34'(chain[N].seg.y1));
         ndx_ff <= 32'(34'(chain[N].x) - 34'(chain[N].seg.x1));
         den_ff <= 33'(34'(chain[N].seg.x2) - 34'(chain[N].seg.x1));
      end
      if (state_ff == sthl_pkg::S_MUL) prod_ff <= {32'd0, mag_ff} * {32'd0, ndx_ff};
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      probe_in  = probe_ff;
      status_in = status_ff;
      height_in = height_ff;
      div_start = 1'b0;
      case (state_ff)
         sthl_pkg::S_IDLE: begin
            if (accept) begin
               status_in = sthl_pkg::ST_OK;
               height_in = '0;
               scan_in   = '0;
               state_in  = sthl_pkg::S_OUT;
               case (req_cmd)
                  sthl_pkg::CMD_ADD: begin
                     if (count_ff >= sthl_pkg::CNT_W'(N)) status_in = sthl_pkg::ST_FULL;
                     else count_in = count_ff + 1'b1;
                  end
                  sthl_pkg::CMD_QUERY: state_in = sthl_pkg::S_SCAN;
                  sthl_pkg::CMD_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         sthl_pkg::S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == ($clog2(N+1))'(N - 1)) begin
               probe_in = chain[N];
               if (!chain[N].found) begin
                  status_in = sthl_pkg::ST_MISS;
                  state_in  = sthl_pkg::S_OUT;
               end else if (chain[N].seg.x1 == chain[N].seg.x2) begin
                  height_in = chain[N].seg.y1;
                  state_in  = sthl_pkg::S_OUT;
               end else state_in = sthl_pkg::S_MUL;
            end
         end
         sthl_pkg::S_MUL: state_in = sthl_pkg::S_DIV;
         sthl_pkg::S_DIV: begin
            div_start = 1'b1;
            state_in  = sthl_pkg::S_DONE;
         end
         sthl_pkg::S_DONE: begin
            if (div_done) begin
               if (sum > 35'sd2147483647) height_in = 32'h7fffffff;
               else if (sum < -35'sd2147483648) height_in = 32'h80000000;
               else height_in = sum[31:0];
               state_in = sthl_pkg::S_OUT;
            end
         end
         sthl_pkg::S_OUT: if (out_load) state_in = sthl_pkg::S_IDLE;
         default: state_in = sthl_pkg::S_IDLE;
      endcase
   end
endmodule

FILE: tb/segment_table_height_lookup_test.sv
// Testbench for the segment table height lookup: adds, clears and queries, checked per beat.
`timescale 1ns / 100ps

module segment_table_height_lookup_test;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 2000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = sthl_pkg::CMD_CLEAR;
   logic signed [31:0] req_left_x = '0;
   logic signed [31:0] req_left_y = '0;
   logic signed [31:0] req_right_x = '0;
   logic signed [31:0] req_right_y = '0;
   logic signed [31:0] req_query_x = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_height_y;

   segment_table_height_lookup dut (.*);

   always #10 clock = ~clock;

   sthl_pkg::seg_type table_copy[sthl_pkg::MAX_SEGMENTS];
   int          table_count = 0;
   logic [1:0]  status_due[$];
   logic [31:0] height_due[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          result_count = 0;
   int          hit_count = 0;
   int          full_count = 0;
   int          send_idle_pct = 23;
   int          recv_idle_pct = 23;
   int          hold_cycles = 0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic logic signed [31:0] line_height(input sthl_pkg::seg_type s,
                                                       input logic signed [31:0] x);
      logic signed [63:0]  dy, dx, den, r;
      logic [127:0]        prod;
      logic [63:0]         mag, q;
      if (s.x1 == s.x2) return s.y1;
      dy  = 64'(s.y2) - 64'(s.y1);
      dx  = 64'(x) - 64'(s.x1);
      den = 64'(s.x2) - 64'(s.x1);
      mag = dy < 0 ? 64'(-dy) : 64'(dy);
      prod = 128'(mag) * 128'(dx);
      q = 64'(prod / 128'(den));
      r = dy < 0 ? 64'(s.y1) - $signed(q) : 64'(s.y1) + $signed(q);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   task automatic predict_result(input logic [1:0] cmd, input sthl_pkg::seg_type s,
                                 input logic signed [31:0] x);
      logic [1:0]         st;
      logic signed [31:0] h;
      int                 hit;
      st = sthl_pkg::ST_OK;
      h = '0;
      hit = -1;
      case (cmd)
         sthl_pkg::CMD_ADD: begin
            if (table_count >= sthl_pkg::MAX_SEGMENTS) st = sthl_pkg::ST_FULL;
            else begin
               table_copy[table_count] = s;
               table_count++;
            end
         end
         sthl_pkg::CMD_QUERY: begin
            for (int i = 0; i < table_count; i++)
               if (x >= table_copy[i].x1 && x <= table_copy[i].x2) hit = i;
            if (hit < 0) st = sthl_pkg::ST_MISS;
            else h = line_height(table_copy[hit], x);
         end
         sthl_pkg::CMD_CLEAR: table_count = 0;
         default: ;
      endcase
      status_due = {status_due, st};
      height_due = {height_due, h};
   endtask

   task automatic send_beat(input logic [1:0] cmd, input sthl_pkg::seg_type s,
                            input logic signed [31:0] x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_left_x  <= s.x1;
      req_left_y  <= s.y1;
      req_right_x <= s.x2;
      req_right_y <= s.y2;
      req_query_x <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_result(cmd, s, x);
      @(negedge clock);
   endtask

   function automatic sthl_pkg::seg_type rand_seg();
      sthl_pkg::seg_type s;
      logic signed [31:0] a, b;
      int                 span;
      case ($urandom_range(9))
         0: begin
            s.x1 = $urandom; s.x2 = $urandom; s.y1 = $urandom; s.y2 = $urandom;
         end
         1: begin
            s.x1 = $urandom_range(200000) - 100000; s.x2 = s.x1;
            s.y1 = $urandom; s.y2 = $urandom;
         end
         default: begin
            span = $urandom_range(3) == 0 ? 32'h7fffffff : 32'h00ffffff;
            a = $signed($urandom_range(span)) - span / 2;
            b = a + $signed($urandom_range(span / 2));
            s.x1 = a; s.x2 = b; s.y1 = $urandom; s.y2 = $urandom;
         end
      endcase
      return s;
   endfunction

   function automatic logic signed [31:0] rand_x();
      int n;
      if (table_count > 0 && $urandom_range(9) < 8) begin
         n = $urandom_range(table_count - 1);
         if (table_copy[n].x2 >= table_copy[n].x1)
            return table_copy[n].x1
               + 32'($urandom_range(32'(table_copy[n].x2 - table_copy[n].x1)));
      end
      return $urandom;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (status_due.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      sthl_pkg::seg_type s;
      s = '{x1: 0, y1: 0, x2: 32'sh00010000, y2: 32'sh00020000};
      send_beat(sthl_pkg::CMD_QUERY, s, 0);
      send_beat(sthl_pkg::CMD_ADD, s, 0);
      send_beat(sthl_pkg::CMD_QUERY, s, 0);
      send_beat(sthl_pkg::CMD_QUERY, s, 32'sh00008000);
      send_beat(sthl_pkg::CMD_QUERY, s, 32'sh00010000);
      send_beat(sthl_pkg::CMD_QUERY, s, 32'sh00010001);
      s = '{x1: 32'sh80000000, y1: 32'sh7fffffff, x2: 32'sh7fffffff, y2: 32'sh80000000};
      send_beat(sthl_pkg::CMD_ADD, s, 0);
      send_beat(sthl_pkg::CMD_QUERY, s, 32'sh80000000);
      send_beat(sthl_pkg::CMD_QUERY, s, 32'sh7fffffff);
      send_beat(sthl_pkg::CMD_QUERY, s, 32'sh00000001);
      s = '{x1: 5, y1: 32'sh12345678, x2: 5, y2: -7};
      send_beat(sthl_pkg::CMD_ADD, s, 0);
      send_beat(sthl_pkg::CMD_QUERY, s, 5);
      s = '{x1: 100, y1: 1, x2: 50, y2: 2};
      send_beat(sthl_pkg::CMD_ADD, s, 0);
      send_beat(sthl_pkg::CMD_QUERY, s, 75);
      s = '{x1: 32'sh80000000, y1: 32'sh80000000, x2: 32'sh7fffffff, y2: 32'sh7fffffff};
      send_beat(sthl_pkg::CMD_ADD, s, 0);
      send_beat(sthl_pkg::CMD_QUERY, s, 32'sh7ffffffe);
      send_beat(CMD_UNUSED, s, 0);
      send_beat(sthl_pkg::CMD_QUERY, s, 32'sh80000001);
      send_beat(sthl_pkg::CMD_CLEAR, s, 0);
      send_beat(sthl_pkg::CMD_QUERY, s, 0);
   endtask

   task automatic test_full_table();
      send_beat(sthl_pkg::CMD_CLEAR, rand_seg(), 0);
      for (int i = 0; i < sthl_pkg::MAX_SEGMENTS + 2; i++)
         send_beat(sthl_pkg::CMD_ADD, rand_seg(), 0);
      for (int i = 0; i < 6; i++) send_beat(sthl_pkg::CMD_QUERY, rand_seg(), rand_x());
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_cycles = 300;
      for (int i = 0; i < 12; i++) send_beat(sthl_pkg::CMD_ADD, rand_seg(), 0);
      for (int i = 0; i < 4; i++) send_beat(sthl_pkg::CMD_QUERY, rand_seg(), rand_x());
      wait_drained();
   endtask

   task automatic test_random(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 4) send_beat(sthl_pkg::CMD_CLEAR, rand_seg(), rand_x());
         else if (r < 6) send_beat(CMD_UNUSED, rand_seg(), rand_x());
         else if (r < 40) send_beat(sthl_pkg::CMD_ADD, rand_seg(), rand_x());
         else send_beat(sthl_pkg::CMD_QUERY, rand_seg(), rand_x());
      end
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (status_due.size() == 0)
            report_mismatch("result beat with nothing expected");
         else begin
            if (rsp_status != status_due[0])
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, status_due[0]));
            if (rsp_height_y != height_due[0])
               report_mismatch($sformatf("height %h, expected %h",
                                         rsp_height_y, height_due[0]));
            if (status_due[0] == sthl_pkg::ST_OK && height_due[0] != 0) hit_count++;
            if (status_due[0] == sthl_pkg::ST_FULL) full_count++;
            void'(status_due.pop_front());
            void'(height_due.pop_front());
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(150);
      send_idle_pct = 23;
      recv_idle_pct = 23;
      test_random(850);
      wait_drained();
      repeat (150) @(negedge clock);
      $display("Covered %0d result beats: %0d nonzero hits, %0d table-full adds,",
               result_count, hit_count, full_count);
      $display("with clears, unused commands, reversed and vertical segments.");
      if (error_count == 0 && status_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
